FILE: design/led_matrix_frame_engine_defines.svh
// Assertion macros used by the frame engine datapath.
`ifndef LED_MATRIX_FRAME_ENGINE_DEFINES_SVH
`define LED_MATRIX_FRAME_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: design/lmfe_pkg.sv
// Types and constants of the LED matrix frame engine.
package lmfe_pkg;

  // command codes
  localparam logic [3:0] ACT_WRITE_PIXEL = 4'd0;
  localparam logic [3:0] ACT_READ_PIXEL  = 4'd1;
  localparam logic [3:0] ACT_FILL        = 4'd2;
  localparam logic [3:0] ACT_DRAW_ROW    = 4'd3;
  localparam logic [3:0] ACT_DRAW_COL    = 4'd4;
  localparam logic [3:0] ACT_READ_ROW    = 4'd5;
  localparam logic [3:0] ACT_READ_COL    = 4'd6;
  localparam logic [3:0] ACT_SHIFT       = 4'd7;
  localparam logic [3:0] ACT_ROTATE      = 4'd8;

  // move directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE = 3'd4;

  localparam logic [4:0] RST_SIZE   = 5'd8;
  localparam logic [7:0] RST_COLOUR = 8'd32;

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] row_index;
    logic [3:0] column_index;
    logic [1:0] direction;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pix_green;
    logic [7:0] pix_red;
    logic [7:0] pix_blue;
    logic       last_pixel;
  } out_word_t;

  // how the cursor maps to a cell
  typedef enum logic [2:0] {
    POS_PIXEL, POS_FILL, POS_ROW, POS_COL, POS_VERT, POS_HORZ
  } pos_mode_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DRAW, S_RD_ADDR, S_RD_DATA,
    S_MV_FIRST, S_MV_SAVE, S_MV_RD, S_MV_WR, S_MV_END
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic draw_wr;
    logic rd;
    logic save;
    logic mv_wr;
    logic end_wr;
    logic step_inc;
    logic lane_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic step_last;
    logic lane_last;
    logic out_free;
  } status_t;

endpackage

FILE: design/led_matrix_frame_engine.sv
// Pixel read: S_RD_ADDR reads the store, S_RD_DATA loads the result word; row/column
// reads repeat both per word, waiting in S_RD_DATA while the output stalls. Draw and fill
// write one cell per cycle; shift/rotate move each lane cell by cell, far edge last,
// through the single read and single write port of the store. Reset: synchronous, active
// low; a clearing pass zeroes the store, taking no command word (config writes are).
module led_matrix_frame_engine #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lmfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmfe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lmfe_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lmfe_pkg::out_word_t             out_word
);
  import lmfe_pkg::*;

  cmd_t    cmd;
  status_t status;

  lmfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_word.action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lmfe_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: design/lmfe_ctrl.sv
// Controller state machine of the frame engine.
module lmfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [3:0]        in_action,
  output logic              in_stall,
  input  lmfe_pkg::status_t status,
  output lmfe_pkg::cmd_t    cmd
);
  import lmfe_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_action)
            ACT_WRITE_PIXEL, ACT_FILL, ACT_DRAW_ROW, ACT_DRAW_COL: state_nxt = S_DRAW;
            ACT_READ_PIXEL, ACT_READ_ROW, ACT_READ_COL:            state_nxt = S_RD_ADDR;
            ACT_SHIFT, ACT_ROTATE:                                 state_nxt = S_MV_FIRST;
            default:                                               state_nxt = S_IDLE;
          endcase
        end
      end
      S_DRAW: begin
        cmd.draw_wr = 1'b1;
        if (status.step_last) begin
          if (status.lane_last) state_nxt = S_IDLE;
          else cmd.lane_next = 1'b1;
        end else begin
          cmd.step_inc = 1'b1;
        end
      end
      S_RD_ADDR: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.step_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step_inc = 1'b1;
            state_nxt    = S_RD_ADDR;
          end
        end
      end
      // first cell of a lane is read; it (rotate) or a zero (shift) is kept for the far edge
      S_MV_FIRST: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MV_SAVE;
      end
      S_MV_SAVE: begin
        cmd.save = 1'b1;
        if (status.step_last) begin
          state_nxt = S_MV_END;
        end else begin
          cmd.step_inc = 1'b1;
          state_nxt    = S_MV_RD;
        end
      end
      S_MV_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        cmd.mv_wr = 1'b1;
        if (status.step_last) begin
          state_nxt = S_MV_END;
        end else begin
          cmd.step_inc = 1'b1;
          state_nxt    = S_MV_RD;
        end
      end
      S_MV_END: begin
        cmd.end_wr = 1'b1;
        if (status.lane_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.lane_next = 1'b1;
          state_nxt     = S_MV_FIRST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/lmfe_dp.sv
// Datapath of the frame engine: config, cursor, frame store and result word.
`include "led_matrix_frame_engine_defines.svh"

module lmfe_dp #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [lmfe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lmfe_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  lmfe_pkg::in_word_t                    in_word,
  input  lmfe_pkg::cmd_t                        cmd,
  output lmfe_pkg::status_t                     status,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output lmfe_pkg::out_word_t                   out_word
);
  import lmfe_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ?
                         ((MAX_WIDTH > 31) ? MAX_WIDTH : 31) :
                         ((MAX_HEIGHT > 31) ? MAX_HEIGHT : 31);
  localparam int NW    = $clog2(MAXD + 1);

  // configuration registers
  logic [4:0] width_r, height_r;
  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SIZE;
      height_r <= RST_SIZE;
      red_r    <= RST_COLOUR;
      green_r  <= RST_COLOUR;
      blue_r   <= RST_COLOUR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[4:0];
        CFG_HEIGHT: height_r <= cfg_data[4:0];
        CFG_RED:    red_r    <= cfg_data;
        CFG_GREEN:  green_r  <= cfg_data;
        CFG_BLUE:   blue_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped area size
  logic [NW-1:0] w_ext, h_ext, w_cl, h_cl, row_in, col_in;
  logic          row_ok, col_ok;

  always_comb begin
    w_ext  = NW'(width_r);
    h_ext  = NW'(height_r);
    w_cl   = (w_ext == '0) ? NW'(1) : ((w_ext > NW'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : w_ext);
    h_cl   = (h_ext == '0) ? NW'(1) : ((h_ext > NW'(MAX_HEIGHT)) ? NW'(MAX_HEIGHT) : h_ext);
    row_in = NW'(in_word.row_index);
    col_in = NW'(in_word.column_index);
    row_ok = row_in < h_cl;
    col_ok = col_in < w_cl;
  end

  // command decode at load
  pos_mode_t     mode_r, mode_nxt;
  logic [NW-1:0] steps_r, steps_nxt, lanes_r, lanes_nxt;
  logic [NW-1:0] row_i_r, col_i_r;
  logic          ok_r, ok_nxt, rev_r, rev_nxt, wrap_r;

  always_comb begin
    mode_nxt  = POS_PIXEL;
    steps_nxt = NW'(1);
    lanes_nxt = NW'(1);
    ok_nxt    = 1'b0;
    rev_nxt   = 1'b0;
    case (in_word.action)
      ACT_WRITE_PIXEL, ACT_READ_PIXEL: begin
        ok_nxt = row_ok && col_ok;
      end
      ACT_FILL: begin
        mode_nxt  = POS_FILL;
        steps_nxt = w_cl;
        lanes_nxt = h_cl;
        ok_nxt    = 1'b1;
      end
      ACT_DRAW_ROW, ACT_READ_ROW: begin
        mode_nxt  = POS_ROW;
        steps_nxt = w_cl;
        ok_nxt    = row_ok;
      end
      ACT_DRAW_COL, ACT_READ_COL: begin
        mode_nxt  = POS_COL;
        steps_nxt = h_cl;
        ok_nxt    = col_ok;
      end
      ACT_SHIFT, ACT_ROTATE: begin
        ok_nxt = 1'b1;
        if (in_word.direction == DIR_UP || in_word.direction == DIR_DOWN) begin
          mode_nxt  = POS_VERT;
          steps_nxt = h_cl;
          lanes_nxt = w_cl;
        end else begin
          mode_nxt  = POS_HORZ;
          steps_nxt = w_cl;
          lanes_nxt = h_cl;
        end
        rev_nxt = (in_word.direction == DIR_DOWN) || (in_word.direction == DIR_RIGHT);
      end
      default: ;
    endcase
  end

  // cursor: lane and step counters
  logic [NW-1:0] step_r, lane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      lane_r  <= '0;
      steps_r <= NW'(1);
      lanes_r <= NW'(1);
    end else if (cmd.load) begin
      step_r  <= '0;
      lane_r  <= '0;
      steps_r <= steps_nxt;
      lanes_r <= lanes_nxt;
    end else if (cmd.lane_next) begin
      step_r <= '0;
      lane_r <= lane_r + NW'(1);
    end else if (cmd.step_inc) begin
      step_r <= step_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode_nxt;
      ok_r    <= ok_nxt;
      rev_r   <= rev_nxt;
      wrap_r  <= (in_word.action == ACT_ROTATE);
      row_i_r <= row_in;
      col_i_r <= col_in;
    end
  end

  // cell addresses of this step and of the step before
  logic [NW-1:0] along, along_prev;
  logic [AW-1:0] cur_addr, prev_addr;

  function automatic logic [AW-1:0] cell_addr(input pos_mode_t m, input logic [NW-1:0] a,
                                              input logic [NW-1:0] ln,
                                              input logic [NW-1:0] ri,
                                              input logic [NW-1:0] ci);
    logic [NW-1:0] r, c;
    case (m)
      POS_FILL: begin r = ln; c = a;  end
      POS_ROW:  begin r = ri; c = a;  end
      POS_COL:  begin r = a;  c = ci; end
      POS_VERT: begin r = a;  c = ln; end
      POS_HORZ: begin r = ln; c = a;  end
      default:  begin r = ri; c = ci; end
    endcase
    return AW'(r * MAX_WIDTH + c);
  endfunction

  always_comb begin
    along      = rev_r ? (steps_r - NW'(1) - step_r) : step_r;
    along_prev = rev_r ? (along + NW'(1)) : (along - NW'(1));
    cur_addr   = cell_addr(mode_r, along, lane_r, row_i_r, col_i_r);
    prev_addr  = cell_addr(mode_r, along_prev, lane_r, row_i_r, col_i_r);
  end

  // clearing pass counter
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // frame store write and read ports
  logic [23:0]   mem [CELLS];
  logic [23:0]   rdata_r, save_r, wdata;
  logic [AW-1:0] waddr;
  logic          we;

  always_comb begin
    we    = cmd.clr_wr || (cmd.draw_wr && ok_r) || cmd.mv_wr || cmd.end_wr;
    waddr = cmd.clr_wr ? clr_cnt_r : (cmd.mv_wr ? prev_addr : cur_addr);
    if (cmd.clr_wr)       wdata = '0;
    else if (cmd.draw_wr) wdata = {green_r, red_r, blue_r};
    else if (cmd.mv_wr)   wdata = rdata_r;
    else                  wdata = save_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[cur_addr];
  end

  // wrapped cell or zero for the far edge
  always_ff @(posedge clk) begin
    if (cmd.save) save_r <= wrap_r ? rdata_r : '0;
  end

  // result word register
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.pix_green  <= ok_r ? rdata_r[23:16] : '0;
      out_word_r.pix_red    <= ok_r ? rdata_r[15:8] : '0;
      out_word_r.pix_blue   <= ok_r ? rdata_r[7:0] : '0;
      out_word_r.last_pixel <= status.step_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // status to the controller
  always_comb begin
    status.clr_done  = (clr_cnt_r == AW'(CELLS - 1));
    status.step_last = (step_r == steps_r - NW'(1));
    status.lane_last = (lane_r == lanes_r - NW'(1));
    status.out_free  = !out_valid_r || !out_stall;
  end

  `ASSERT_ALWAYS(a_one_writer, clk, rst_n,
    $onehot0({cmd.clr_wr, cmd.draw_wr, cmd.mv_wr, cmd.end_wr}))
  `ASSERT_ALWAYS(a_step_in_run, clk, rst_n, step_r < steps_r)
  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall)
  `ASSERT_IMPL(a_end_at_edge, clk, rst_n, cmd.end_wr, status.step_last)

endmodule
